// ----- hw/rtl/uas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uas_pkg - shared types and constants for the unique address set
// Operation codes, field widths, controller states and the command/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package uas_pkg;

   localparam int IP_W   = 32;
   localparam int MODE_W = 2;
   localparam int SIZE_W = 9;
   localparam int RSP_W  = 16;

   typedef logic [MODE_W-1:0] mode_type;

   // unused code 3 behaves as a query
   localparam mode_type MODE_ADD   = 2'd0;
   localparam mode_type MODE_QUERY = 2'd1;
   localparam mode_type MODE_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;    // latch a new item, rewind the scan
      logic scan;     // walk the filled entries
      logic finish;   // commit the update and load the result
   } cmd_type;

   typedef struct packed {
      logic hit;       // stored entry matches the address
      logic scan_done; // all filled entries checked
      logic out_busy;  // result register still holds an untaken item
   } sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/uas_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uas_ctrl - sequencing state machine
// Takes one item at a time, runs the search over the filled entries and
// hands the outcome to the datapath once the result register is free.
// ----------------------------------------------------------------------------
module uas_ctrl (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_tvalid,
   output logic            req_tready,
   input  uas_pkg::sts_type sts_i,
   output uas_pkg::cmd_type cmd_o
);
   import uas_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // stop early on a match
            if (sts_i.hit || sts_i.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts_i.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd_o        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd_o.start  = req_tvalid;
         end
         ST_SCAN: begin
            cmd_o.scan   = 1'b1;
         end
         ST_FINISH: begin
            cmd_o.finish = !sts_i.out_busy;
         end
         default: begin
            req_tready   = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/uas_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uas_dpath - entry store, search pointer, fill count and result register
// The store has one write port and one registered read port; the scan
// reads one entry a cycle and compares it in the next.
// ----------------------------------------------------------------------------
module uas_dpath #(
   parameter int CAPACITY = 256
) (
   input  wire                         clock,
   input  wire                         reset,
   input  uas_pkg::cmd_type            cmd_i,
   output uas_pkg::sts_type            sts_o,
   input  wire [uas_pkg::MODE_W-1:0]   req_mode,
   input  wire [uas_pkg::IP_W-1:0]     req_ip,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [uas_pkg::RSP_W-1:0]   rsp_tdata
);
   import uas_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PAD_W = RSP_W - 3 - SIZE_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [IP_W-1:0]   mem_ff [CAPACITY];
   logic [IP_W-1:0]   rd_data_ff;
   mode_type          mode_ff;
   logic [IP_W-1:0]   ip_ff;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rd_vld_ff;
   logic              found_ff, found_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              rsp_present_ff, rsp_added_ff, rsp_full_ff;
   logic [SIZE_W-1:0] rsp_size_ff;

   logic issue, hit, add_new, room, wr_en, is_clear;

   assign is_clear = (mode_ff == MODE_CLEAR);
   assign issue    = cmd_i.scan && !is_clear && (idx_ff != count_ff);
   assign hit      = rd_vld_ff && (rd_data_ff == ip_ff);
   assign add_new  = (mode_ff == MODE_ADD) && !found_ff;
   assign room     = (count_ff != CAP_C);
   assign wr_en    = cmd_i.finish && add_new && room;

   assign sts_o.hit       = hit;
   assign sts_o.scan_done = !issue && !rd_vld_ff;
   assign sts_o.out_busy  = rsp_tvalid_ff && !rsp_tready;

   // entry store
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[count_ff[AW-1:0]] <= ip_ff;
      if (issue) rd_data_ff <= mem_ff[idx_ff[AW-1:0]];
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd_i.start) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_comb begin
      found_in = found_ff;
      if (cmd_i.start) begin
         found_in = 1'b0;
      end else if (cmd_i.scan && hit) begin
         found_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd_i.finish && is_clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd_i.finish) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         rd_vld_ff     <= issue;
         found_ff      <= found_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd_i.start) begin
         mode_ff <= req_mode;
         ip_ff   <= req_ip;
      end
      if (cmd_i.finish) begin
         rsp_present_ff <= found_ff;
         rsp_added_ff   <= wr_en;
         rsp_full_ff    <= add_new && !room;
         rsp_size_ff    <= SIZE_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_size_ff, rsp_full_ff, rsp_added_ff,
                        rsp_present_ff};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("fill count above capacity");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_i.scan |-> idx_ff <= count_ff)
      else $error("search pointer passed fill count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_i.finish |-> !(rsp_tvalid_ff && !rsp_tready))
      else $error("result register overwritten");

   a_append: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("append did not advance fill count");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd_i.start, cmd_i.scan, cmd_i.finish}))
      else $error("overlapping commands");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/unique_address_set.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// unique_address_set - set of unique IPv4 addresses with linear search
// Keeps up to CAPACITY addresses in insertion order; add, query, clear.
//
//   channel  dir  tdata                                  tuser
//   req      in   [31:0] ip                              [1:0] mode
//   rsp      out  [0] present [1] added [2] full_res     -
//                 [11:3] set_size [15:12] zero
//
// A match at entry k ends the search early. The single read port of the
// entry store limits the search to one entry a cycle. Reset empties the
// set at once; no clearing pass.
// One item is in work at a time; a finished result waits in an output
// register while the next item is taken, and a stalled rsp holds the next.
// ----------------------------------------------------------------------------
module unique_address_set #(
   parameter int CAPACITY = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [31:0]  req_tdata,   // [31:0] ip
   input  wire [1:0]   req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata    // present, added, full_res, set_size[8:0], pad
);
   import uas_pkg::*;

   cmd_type cmd;
   sts_type sts;

   uas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts_i      (sts),
      .cmd_o      (cmd)
   );

   uas_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd_i      (cmd),
      .sts_o      (sts),
      .req_mode   (req_tuser),
      .req_ip     (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - unique address set
// Drives add, query and clear items into the req stream and checks every rsp
// item against a shadow copy of the address store or a hand-written expectation.
//
// The run has two parts. A short directed table covers the empty set, the
// address extremes, repeats, the spare mode code and clears over stale
// entries. Random episodes follow. Each idling phase starts with one episode
// that fills the store to capacity and then keeps sending adds and queries to
// the full store. Short episodes with stored, bit-flipped, stale and fresh
// addresses fill the rest of the phase.
// ----------------------------------------------------------------------------
module testbench;
   import uas_pkg::*;

   localparam int CAPACITY     = 256;
   localparam int PHASE_ITEMS  = 450;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY;
   localparam int NUM_DIRECTED = 21;

   // spare code, behaves as a query
   localparam mode_type MODE_SPARE = 2'd3;

   typedef struct packed {
      logic              present;
      logic              added;
      logic              full_res;
      logic [SIZE_W-1:0] set_size;
   } set_status_type;

   typedef struct packed {
      mode_type       mode;
      logic [31:0]    ip;
      logic           typed;   // want holds a hand-written expectation
      set_status_type want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;     // [31:0] ip
   logic [1:0]  req_tuser  = '0;     // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [0] present [1] added [2] full_res [11:3] set_size

   // shadow of the address store
   logic [IP_W-1:0] shadow_addr [CAPACITY];
   int              shadow_count = 0;
   int              written_top  = 0;   // slots below this hold a real address

   set_status_type awaited_status [$];
   set_status_type got_status;
   set_status_type want_status;

   int send_idle_pct = 20;
   int recv_idle_pct = 70;
   int idle_cycles   = 0;
   int faults        = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int n_hits        = 0;
   int n_rejects     = 0;
   int n_clears      = 0;

   stim_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{MODE_QUERY, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 1'b0, 9'd0}},
      '{MODE_ADD,   32'h0000_0000, 1'b1, '{1'b0, 1'b1, 1'b0, 9'd1}},
      '{MODE_ADD,   32'h0000_0000, 1'b1, '{1'b1, 1'b0, 1'b0, 9'd1}},
      '{MODE_ADD,   32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 1'b0, 9'd2}},
      '{MODE_QUERY, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 1'b0, 9'd2}},
      '{MODE_QUERY, 32'hFFFF_FFFE, 1'b1, '{1'b0, 1'b0, 1'b0, 9'd2}},
      '{MODE_SPARE, 32'hFFFF_FFFF, 1'b0, '0},
      '{MODE_SPARE, 32'h1234_5678, 1'b0, '0},
      '{MODE_ADD,   32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b1, 1'b0, 9'd3}},
      '{MODE_ADD,   32'h8000_0000, 1'b1, '{1'b0, 1'b1, 1'b0, 9'd4}},
      '{MODE_QUERY, 32'h0000_0001, 1'b0, '0},
      '{MODE_CLEAR, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 1'b0, 9'd0}},
      '{MODE_QUERY, 32'h0000_0000, 1'b0, '0},
      '{MODE_ADD,   32'h8000_0000, 1'b0, '0},
      '{MODE_CLEAR, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 1'b0, 9'd0}},
      '{MODE_CLEAR, 32'h1234_5678, 1'b1, '{1'b0, 1'b0, 1'b0, 9'd0}},
      '{MODE_ADD,   32'hA5A5_A5A5, 1'b0, '0},
      '{MODE_ADD,   32'h5A5A_5A5A, 1'b0, '0},
      '{MODE_QUERY, 32'h5A5A_5A5A, 1'b0, '0},
      '{MODE_SPARE, 32'h0000_0000, 1'b0, '0},
      '{MODE_ADD,   32'hA5A5_A5A5, 1'b0, '0}
   };

   unique_address_set #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Apply one operation to the shadow store and return the status it gives.
   function automatic set_status_type apply_set_op(mode_type m, logic [IP_W-1:0] ip);
      set_status_type st;
      int             i;
      st = '0;
      if (m == MODE_CLEAR) begin
         shadow_count = 0;
         n_clears++;
      end else begin
         for (i = 0; i < shadow_count; i++) begin
            if (shadow_addr[i] == ip) st.present = 1'b1;
         end
         if (st.present) n_hits++;
         if (m == MODE_ADD && !st.present) begin
            if (shadow_count < CAPACITY) begin
               shadow_addr[shadow_count] = ip;
               shadow_count++;
               if (shadow_count > written_top) written_top = shadow_count;
               st.added = 1'b1;
            end else begin
               st.full_res = 1'b1;
               n_rejects++;
            end
         end
      end
      st.set_size = shadow_count[SIZE_W-1:0];
      return st;
   endfunction

   // Pick an address: fresh, stored, one bit off a stored one, or left over
   // beyond the fill count.
   function automatic logic [IP_W-1:0] pick_addr();
      int r;
      r = $urandom_range(0, 9);
      if (r >= 4 && r <= 6 && shadow_count > 0)
         return shadow_addr[$urandom_range(0, shadow_count - 1)];
      if (r >= 7 && r <= 8 && shadow_count > 0)
         return shadow_addr[$urandom_range(0, shadow_count - 1)] ^ (32'h1 << $urandom_range(0, 31));
      if (r == 9 && written_top > shadow_count)
         return shadow_addr[$urandom_range(shadow_count, written_top - 1)];
      return $urandom();
   endfunction

   task automatic send_op(input mode_type m, input logic [IP_W-1:0] ip,
                          input logic typed, input set_status_type want);
      set_status_type st;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      st = apply_set_op(m, ip);
      awaited_status.push_back(typed ? want : st);
      req_tvalid <= 1'b1;
      req_tdata  <= ip;
      req_tuser  <= m;
      items_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic random_op(input bit allow_clear);
      int pick;
      pick = $urandom_range(0, 99);
      if (allow_clear && pick >= 96)
         send_op(MODE_CLEAR, $urandom(), 1'b0, '0);
      else if (pick < 50)
         send_op(MODE_ADD, pick_addr(), 1'b0, '0);
      else if (pick < 88)
         send_op(MODE_QUERY, pick_addr(), 1'b0, '0);
      else
         send_op(MODE_SPARE, pick_addr(), 1'b0, '0);
   endtask

   task automatic run_episode(input bit fill_up);
      int ops;
      int k;
      if (fill_up || $urandom_range(0, 3) != 0) send_op(MODE_CLEAR, $urandom(), 1'b0, '0);
      if (fill_up) begin
         // mostly fresh adds until the store is full, then keep pushing on it
         while (shadow_count < CAPACITY) begin
            if ($urandom_range(0, 99) < 80) send_op(MODE_ADD, $urandom(), 1'b0, '0);
            else random_op(1'b0);
         end
         for (k = 0; k < 24; k++) random_op(1'b0);
      end else begin
         ops = $urandom_range(3, 30);
         for (k = 0; k < ops; k++) random_op(1'b1);
      end
   endtask

   // result side: check each item, then stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status.present  = rsp_tdata[0];
         got_status.added    = rsp_tdata[1];
         got_status.full_res = rsp_tdata[2];
         got_status.set_size = rsp_tdata[11:3];
         results_seen++;
         if (awaited_status.size() == 0) begin
            $error("rsp item with no request waiting: tdata %h", rsp_tdata);
            faults++;
         end else begin
            want_status = awaited_status.pop_front();
            if (got_status.present !== want_status.present) begin
               $error("present: expected %0d, got %0d", want_status.present, got_status.present);
               faults++;
            end
            if (got_status.added !== want_status.added) begin
               $error("added: expected %0d, got %0d", want_status.added, got_status.added);
               faults++;
            end
            if (got_status.full_res !== want_status.full_res) begin
               $error("full_res: expected %0d, got %0d", want_status.full_res,
                      got_status.full_res);
               faults++;
            end
            if (got_status.set_size !== want_status.set_size) begin
               $error("set_size: expected %0d, got %0d", want_status.set_size,
                      got_status.set_size);
               faults++;
            end
            if (rsp_tdata[15:12] !== 4'd0) begin
               $error("pad: expected 0, got %h", rsp_tdata[15:12]);
               faults++;
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int row;
      int ph;
      int phase_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 70;
      for (row = 0; row < NUM_DIRECTED; row++) begin
         send_op(directed_rows[row].mode, directed_rows[row].ip,
                 directed_rows[row].typed, directed_rows[row].want);
      end

      for (ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 70 : 0;
         recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 20 : 0;
         phase_start = items_sent;
         run_episode(1'b1);
         while (items_sent - phase_start < PHASE_ITEMS) run_episode(1'b0);
      end
      req_tvalid <= 1'b0;

      while (awaited_status.size() != 0) @(posedge clock);
      // hold for any stray result
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("items %0d, results %0d, hits %0d, clears %0d, adds rejected on full store %0d",
               items_sent, results_seen, n_hits, n_clears, n_rejects);
      $display("store filled to %0d entries in each of three idling phases", CAPACITY);
      if (faults == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
